>>> design/assert_macros.svh
// Assertion macros shared by the sentence parser modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define TSP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Expression must never be true outside reset.
`define TSP_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("forbidden condition seen");

`else

`define TSP_ASSERT(lbl, clk, rst_n, prop)
`define TSP_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

>>> design/tsp_pkg.sv
// Types, character codes and helpers of the telemetry sentence parser.
package tsp_pkg;

    // Characters of the sentence grammar
    localparam logic [7:0] C_DOLLAR = 8'h24;
    localparam logic [7:0] C_STAR   = 8'h2A;
    localparam logic [7:0] C_COMMA  = 8'h2C;
    localparam logic [7:0] C_POINT  = 8'h2E;
    localparam logic [7:0] C_MINUS  = 8'h2D;
    localparam logic [7:0] C_PLUS   = 8'h2B;
    localparam logic [7:0] C_ZERO   = 8'h30;
    localparam logic [7:0] C_ONE    = 8'h31;
    localparam logic [7:0] C_NINE   = 8'h39;
    localparam logic [7:0] C_R      = 8'h52;
    localparam logic [7:0] C_V      = 8'h56;
    localparam logic [7:0] C_N      = 8'h4E;
    localparam logic [7:0] C_S      = 8'h53;
    localparam logic [7:0] C_E      = 8'h45;
    localparam logic [7:0] C_W      = 8'h57;

    // Offsets of digit values
    localparam logic [7:0] DEC_BASE = 8'd48;
    localparam logic [7:0] HEX_BASE = 8'd55;

    // Field numbers within a sentence
    localparam logic [7:0] F_VALID    = 8'd0;
    localparam logic [7:0] F_UNITS    = 8'd1;
    localparam logic [7:0] F_LAT      = 8'd3;
    localparam logic [7:0] F_LAT_HEMI = 8'd4;
    localparam logic [7:0] F_LON      = 8'd5;
    localparam logic [7:0] F_LON_SIDE = 8'd6;
    localparam logic [7:0] F_ALT      = 8'd8;
    localparam logic [7:0] F_SATS     = 8'd23;

    // Sign codes
    localparam logic [1:0] SIGN_NONE = 2'b00;
    localparam logic [1:0] SIGN_POS  = 2'b01;
    localparam logic [1:0] SIGN_NEG  = 2'b11;

    // Checksum digits that close a frame
    localparam logic [1:0] CHK_DIGITS_END = 2'd2;

    // Exact unsigned 32-bit division by 100: (x * 0x51EB851F) >> 37
    localparam logic [31:0] DIV100_MUL   = 32'h51EB_851F;
    localparam int          DIV100_SHIFT = 37;

    localparam int W_TDATA = 96;
    localparam int W_TUSER = 2;

    // Snapshot of a closed frame, handed from the parser to the output stage
    typedef struct packed {
        logic               ok;
        logic [1:0]         lat_sign;
        logic [15:0]        lat_whole;
        logic [31:0]        lat_frac;
        logic [1:0]         lon_sign;
        logic [15:0]        lon_whole;
        logic [31:0]        lon_frac;
        logic signed [15:0] altitude;
        logic [7:0]         satellites;
        logic               metric;
    } t_frame_evt;

    function automatic logic [15:0] f_div100(input logic [31:0] x);
        logic [63:0] p;
        p = {32'd0, x} * {32'd0, DIV100_MUL};
        return p[DIV100_SHIFT+15:DIV100_SHIFT];
    endfunction

endpackage

>>> design/tsp_parser.sv
// Byte-level sentence state: checksum, field counter, accumulators and frame close event.
`include "assert_macros.svh"

module tsp_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_byte_valid,
    output logic                  o_byte_ready,
    input  logic [7:0]            i_byte,
    output logic                  o_evt_valid,
    input  logic                  i_evt_ready,
    output tsp_pkg::t_frame_evt   o_evt
);

    logic        r_frame_active, n_frame_active;
    logic        r_in_checksum,  n_in_checksum;
    logic [7:0]  r_xor,          n_xor;
    logic [15:0] r_cs_rx,        n_cs_rx;
    logic [1:0]  r_cs_digits,    n_cs_digits;
    logic [7:0]  r_field,        n_field;
    logic        r_point_seen,   n_point_seen;
    logic [15:0] r_lat_whole,    n_lat_whole;
    logic [31:0] r_lat_frac,     n_lat_frac;
    logic [15:0] r_lon_whole,    n_lon_whole;
    logic [31:0] r_lon_frac,     n_lon_frac;
    logic [1:0]  r_lat_sign,     n_lat_sign;
    logic [1:0]  r_lon_sign,     n_lon_sign;
    logic [15:0] r_alt,          n_alt;
    logic [1:0]  r_alt_sign,     n_alt_sign;
    logic [7:0]  r_sats,         n_sats;
    logic        r_metric,       n_metric;

    logic                 r_evt_valid;
    tsp_pkg::t_frame_evt  r_evt;
    tsp_pkg::t_frame_evt  w_evt;

    logic        w_fire;
    logic        w_end;
    logic [7:0]  w_c;
    logic [7:0]  w_dig8;
    logic [15:0] w_dig16;
    logic [31:0] w_dig32;
    logic [15:0] w_hex_add;
    logic [15:0] w_alt_val;

    assign o_byte_ready = !r_evt_valid || i_evt_ready;
    assign w_fire       = i_byte_valid && o_byte_ready;
    assign w_c          = i_byte;

    // Digit values wrap at the width of the accumulator they feed
    assign w_dig8  = w_c - tsp_pkg::DEC_BASE;
    assign w_dig16 = {8'd0, w_c} - {8'd0, tsp_pkg::DEC_BASE};
    assign w_dig32 = {24'd0, w_c} - {24'd0, tsp_pkg::DEC_BASE};

    always_comb begin
        if (w_c inside {[tsp_pkg::C_ZERO:tsp_pkg::C_NINE]}) begin
            w_hex_add = w_dig16;
        end else begin
            w_hex_add = {8'd0, w_c} - {8'd0, tsp_pkg::HEX_BASE};
        end
    end

    always_comb begin
        case (r_alt_sign)
            tsp_pkg::SIGN_POS: w_alt_val = r_alt;
            tsp_pkg::SIGN_NEG: w_alt_val = 16'd0 - r_alt;
            default:           w_alt_val = 16'd0;
        endcase
    end

    always_comb begin
        w_evt.ok         = (r_cs_rx == {8'd0, r_xor});
        w_evt.lat_sign   = r_lat_sign;
        w_evt.lat_whole  = r_lat_whole;
        w_evt.lat_frac   = r_lat_frac;
        w_evt.lon_sign   = r_lon_sign;
        w_evt.lon_whole  = r_lon_whole;
        w_evt.lon_frac   = r_lon_frac;
        w_evt.altitude   = $signed(w_alt_val);
        w_evt.satellites = r_sats;
        w_evt.metric     = r_metric;
    end

    always_comb begin
        n_frame_active = r_frame_active;
        n_in_checksum  = r_in_checksum;
        n_xor          = r_xor;
        n_cs_rx        = r_cs_rx;
        n_cs_digits    = r_cs_digits;
        n_field        = r_field;
        n_point_seen   = r_point_seen;
        n_lat_whole    = r_lat_whole;
        n_lat_frac     = r_lat_frac;
        n_lon_whole    = r_lon_whole;
        n_lon_frac     = r_lon_frac;
        n_lat_sign     = r_lat_sign;
        n_lon_sign     = r_lon_sign;
        n_alt          = r_alt;
        n_alt_sign     = r_alt_sign;
        n_sats         = r_sats;
        n_metric       = r_metric;
        w_end          = 1'b0;

        if (w_fire) begin
            if (!r_frame_active) begin
                // open a frame; units flag and point flag survive
                if (w_c == tsp_pkg::C_DOLLAR) begin
                    n_frame_active = 1'b1;
                    n_in_checksum  = 1'b0;
                    n_xor          = 8'd0;
                    n_cs_rx        = 16'd0;
                    n_cs_digits    = 2'd0;
                    n_field        = 8'd0;
                    n_lat_whole    = 16'd0;
                    n_lat_frac     = 32'd0;
                    n_lon_whole    = 16'd0;
                    n_lon_frac     = 32'd0;
                    n_lat_sign     = tsp_pkg::SIGN_NONE;
                    n_lon_sign     = tsp_pkg::SIGN_NONE;
                    n_alt          = 16'd0;
                    n_alt_sign     = tsp_pkg::SIGN_NONE;
                    n_sats         = 8'd0;
                end
            end else if (w_c == tsp_pkg::C_R || w_c == tsp_pkg::C_V) begin
                n_xor = r_xor ^ w_c;
            end else if (w_c == tsp_pkg::C_STAR) begin
                n_in_checksum = 1'b1;
            end else if (r_cs_digits == tsp_pkg::CHK_DIGITS_END) begin
                // a byte other than R, V or star after the checksum digits closes the frame
                w_end          = 1'b1;
                n_frame_active = 1'b0;
            end else begin
                if (r_in_checksum) begin
                    n_cs_digits = r_cs_digits + 2'd1;
                    n_cs_rx     = {r_cs_rx[11:0], 4'd0} + w_hex_add;
                end else begin
                    n_xor = r_xor ^ w_c;
                end

                if (w_c == tsp_pkg::C_COMMA) begin
                    n_field      = r_field + 8'd1;
                    n_point_seen = 1'b0;
                end else begin
                    case (r_field)
                        tsp_pkg::F_VALID: begin
                            if (w_c == tsp_pkg::C_ZERO) n_frame_active = 1'b0;
                        end
                        tsp_pkg::F_UNITS: begin
                            if (w_c == tsp_pkg::C_ZERO)     n_metric = 1'b0;
                            else if (w_c == tsp_pkg::C_ONE) n_metric = 1'b1;
                        end
                        tsp_pkg::F_LAT: begin
                            if (w_c == tsp_pkg::C_POINT) begin
                                n_point_seen = 1'b1;
                            end else if (!r_point_seen) begin
                                n_lat_whole = (r_lat_whole << 3) + (r_lat_whole << 1) + w_dig16;
                            end else begin
                                n_lat_frac = (r_lat_frac << 3) + (r_lat_frac << 1) + w_dig32;
                            end
                        end
                        tsp_pkg::F_LAT_HEMI: begin
                            if (w_c == tsp_pkg::C_N)      n_lat_sign = tsp_pkg::SIGN_POS;
                            else if (w_c == tsp_pkg::C_S) n_lat_sign = tsp_pkg::SIGN_NEG;
                        end
                        tsp_pkg::F_LON: begin
                            if (w_c == tsp_pkg::C_POINT) begin
                                n_point_seen = 1'b1;
                            end else if (!r_point_seen) begin
                                n_lon_whole = (r_lon_whole << 3) + (r_lon_whole << 1) + w_dig16;
                            end else begin
                                n_lon_frac = (r_lon_frac << 3) + (r_lon_frac << 1) + w_dig32;
                            end
                        end
                        tsp_pkg::F_LON_SIDE: begin
                            if (w_c == tsp_pkg::C_E)      n_lon_sign = tsp_pkg::SIGN_POS;
                            else if (w_c == tsp_pkg::C_W) n_lon_sign = tsp_pkg::SIGN_NEG;
                        end
                        tsp_pkg::F_ALT: begin
                            if (w_c == tsp_pkg::C_POINT) begin
                                n_point_seen = 1'b1;
                            end else if (w_c == tsp_pkg::C_MINUS) begin
                                n_alt_sign = tsp_pkg::SIGN_NEG;
                            end else if (w_c == tsp_pkg::C_PLUS) begin
                                n_alt_sign = tsp_pkg::SIGN_POS;
                            end else if (!r_point_seen) begin
                                n_alt = (r_alt << 3) + (r_alt << 1) + w_dig16;
                            end
                        end
                        tsp_pkg::F_SATS: begin
                            n_sats = (r_sats << 3) + (r_sats << 1) + w_dig8;
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_active <= 1'b0;
            r_in_checksum  <= 1'b0;
            r_xor          <= 8'd0;
            r_cs_rx        <= 16'd0;
            r_cs_digits    <= 2'd0;
            r_field        <= 8'd0;
            r_point_seen   <= 1'b0;
            r_lat_whole    <= 16'd0;
            r_lat_frac     <= 32'd0;
            r_lon_whole    <= 16'd0;
            r_lon_frac     <= 32'd0;
            r_lat_sign     <= tsp_pkg::SIGN_NONE;
            r_lon_sign     <= tsp_pkg::SIGN_NONE;
            r_alt          <= 16'd0;
            r_alt_sign     <= tsp_pkg::SIGN_NONE;
            r_sats         <= 8'd0;
            r_metric       <= 1'b0;
            r_evt_valid    <= 1'b0;
        end else begin
            r_frame_active <= n_frame_active;
            r_in_checksum  <= n_in_checksum;
            r_xor          <= n_xor;
            r_cs_rx        <= n_cs_rx;
            r_cs_digits    <= n_cs_digits;
            r_field        <= n_field;
            r_point_seen   <= n_point_seen;
            r_lat_whole    <= n_lat_whole;
            r_lat_frac     <= n_lat_frac;
            r_lon_whole    <= n_lon_whole;
            r_lon_frac     <= n_lon_frac;
            r_lat_sign     <= n_lat_sign;
            r_lon_sign     <= n_lon_sign;
            r_alt          <= n_alt;
            r_alt_sign     <= n_alt_sign;
            r_sats         <= n_sats;
            r_metric       <= n_metric;
            if (w_end) begin
                r_evt_valid <= 1'b1;
            end else if (i_evt_ready) begin
                r_evt_valid <= 1'b0;
            end
        end
    end

    // Event payload needs no reset
    always_ff @(posedge i_clk) begin
        if (w_end) begin
            r_evt <= w_evt;
        end
    end

    assign o_evt_valid = r_evt_valid;
    assign o_evt       = r_evt;

    `TSP_NEVER(a_digits_range, i_clk, i_rst_n, r_cs_digits == 2'd3)
    `TSP_ASSERT(a_digits_need_star, i_clk, i_rst_n, (r_cs_digits != 2'd0) |-> r_in_checksum)
    `TSP_ASSERT(a_evt_closes_frame, i_clk, i_rst_n,
        $rose(r_evt_valid) |-> ($past(r_frame_active) && !r_frame_active))

endmodule

>>> design/telemetry_sentence_parser.sv
// Top level of the telemetry sentence parser: byte stream in, one position result per closed frame out.
//
//   channel  | dir | tdata                                    | tuser
//   ---------+-----+------------------------------------------+------------------------------
//   s        | in  | [7:0] rx_byte                            | -
//   m        | out | lat_sign, lat_whole, lat_frac, lon_sign, | [0] checksum_ok,
//            |     | lon_whole, lon_frac, altitude, satellites| [1] metric_units
//
// One byte is taken every cycle while the input is not stalled; the result of a frame is
// registered first as the parser's frame event, when the byte that closes the frame is
// taken, then in the output register, with the divide by 100 of the fractions in front of it.
// Reset is synchronous, active low, and clears parser and held position state, but not the event and output payloads.
// The input stalls only while a closed frame waits behind an output result that
// has not been taken; a waiting result alone does not stop byte intake.
`include "assert_macros.svh"

module telemetry_sentence_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [7:0]                  i_s_tdata,   // [7:0] rx_byte
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // [1:0] lat_sign, [17:2] lat_whole, [33:18] lat_frac, [35:34] lon_sign,
    // [51:36] lon_whole, [67:52] lon_frac, [83:68] altitude, [91:84] satellites
    output logic [tsp_pkg::W_TDATA-1:0] o_m_tdata,
    output logic [tsp_pkg::W_TUSER-1:0] o_m_tuser    // [0] checksum_ok, [1] metric_units
);

    logic                 w_evt_valid;
    logic                 w_evt_ready;
    logic                 w_evt_fire;
    tsp_pkg::t_frame_evt  w_evt;

    logic [1:0]  r_held_lat_sign,  n_held_lat_sign;
    logic [15:0] r_held_lat_whole, n_held_lat_whole;
    logic [15:0] r_held_lat_frac,  n_held_lat_frac;
    logic [1:0]  r_held_lon_sign,  n_held_lon_sign;
    logic [15:0] r_held_lon_whole, n_held_lon_whole;
    logic [15:0] r_held_lon_frac,  n_held_lon_frac;

    logic [15:0] w_lat_q;
    logic [15:0] w_lon_q;

    logic                        r_out_valid;
    logic [tsp_pkg::W_TDATA-1:0] r_out_data;
    logic [tsp_pkg::W_TUSER-1:0] r_out_user;

    tsp_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (i_s_tvalid),
        .o_byte_ready (o_s_tready),
        .i_byte       (i_s_tdata),
        .o_evt_valid  (w_evt_valid),
        .i_evt_ready  (w_evt_ready),
        .o_evt        (w_evt)
    );

    assign w_evt_ready = !r_out_valid || i_m_tready;
    assign w_evt_fire  = w_evt_valid && w_evt_ready;

    assign w_lat_q = tsp_pkg::f_div100(w_evt.lat_frac);
    assign w_lon_q = tsp_pkg::f_div100(w_evt.lon_frac);

    // Replace the held position only on a matching checksum
    always_comb begin
        n_held_lat_sign  = r_held_lat_sign;
        n_held_lat_whole = r_held_lat_whole;
        n_held_lat_frac  = r_held_lat_frac;
        n_held_lon_sign  = r_held_lon_sign;
        n_held_lon_whole = r_held_lon_whole;
        n_held_lon_frac  = r_held_lon_frac;
        if (w_evt_fire && w_evt.ok) begin
            n_held_lat_sign  = w_evt.lat_sign;
            n_held_lat_whole = w_evt.lat_whole;
            n_held_lat_frac  = w_lat_q;
            n_held_lon_sign  = w_evt.lon_sign;
            n_held_lon_whole = w_evt.lon_whole;
            n_held_lon_frac  = w_lon_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_lat_sign  <= tsp_pkg::SIGN_NONE;
            r_held_lat_whole <= 16'd0;
            r_held_lat_frac  <= 16'd0;
            r_held_lon_sign  <= tsp_pkg::SIGN_NONE;
            r_held_lon_whole <= 16'd0;
            r_held_lon_frac  <= 16'd0;
            r_out_valid      <= 1'b0;
        end else begin
            r_held_lat_sign  <= n_held_lat_sign;
            r_held_lat_whole <= n_held_lat_whole;
            r_held_lat_frac  <= n_held_lat_frac;
            r_held_lon_sign  <= n_held_lon_sign;
            r_held_lon_whole <= n_held_lon_whole;
            r_held_lon_frac  <= n_held_lon_frac;
            if (w_evt_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_evt_fire) begin
            r_out_data <= {4'd0,
                           w_evt.satellites,
                           w_evt.altitude,
                           n_held_lon_frac,
                           n_held_lon_whole,
                           n_held_lon_sign,
                           n_held_lat_frac,
                           n_held_lat_whole,
                           n_held_lat_sign};
            r_out_user <= {w_evt.metric, w_evt.ok};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    `TSP_ASSERT(a_evt_gives_result, i_clk, i_rst_n, w_evt_fire |=> o_m_tvalid)
    `TSP_ASSERT(a_bad_sum_holds_pos, i_clk, i_rst_n,
        (w_evt_fire && !w_evt.ok) |=> ($stable(r_held_lat_whole) && $stable(r_held_lon_whole)
            && $stable(r_held_lat_frac) && $stable(r_held_lon_frac)))
    `TSP_ASSERT(a_stall_only_when_full, i_clk, i_rst_n,
        !o_s_tready |-> (o_m_tvalid && !i_m_tready && w_evt_valid))

endmodule

>>> dv/telemetry_sentence_parser_checker.sv
// Checker for the telemetry sentence parser: predicts each frame result and compares it.
module telemetry_sentence_parser_checker
    import tsp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    input  logic               i_s_tready,
    input  logic [7:0]         i_s_tdata,   // [7:0] rx_byte
    input  logic               i_m_tvalid,
    input  logic               i_m_tready,
    // [1:0] lat_sign, [17:2] lat_whole, [33:18] lat_frac, [35:34] lon_sign,
    // [51:36] lon_whole, [67:52] lon_frac, [83:68] altitude, [91:84] satellites
    input  logic [W_TDATA-1:0] i_m_tdata,
    input  logic [W_TUSER-1:0] i_m_tuser,   // [0] checksum_ok, [1] metric_units
    output int                 o_errors,
    output int                 o_outstanding
);

    localparam logic [31:0] DEC_RADIX  = 32'd10;
    localparam logic [15:0] HEX_RADIX  = 16'd16;
    localparam logic [31:0] FRAC_SCALE = 32'd100;

    typedef struct packed {
        logic               ok;
        logic [1:0]         lat_sign;
        logic [15:0]        lat_whole;
        logic [15:0]        lat_frac;
        logic [1:0]         lon_sign;
        logic [15:0]        lon_whole;
        logic [15:0]        lon_frac;
        logic [15:0]        altitude;
        logic [7:0]         satellites;
        logic               metric;
    } t_fix;

    t_fix fixes_due[$];
    int   fault_count = 0;
    int   fix_index   = 0;

    // Parser state
    logic        in_frame;
    logic        in_star;
    logic [7:0]  sum_xor;
    logic [15:0] chk_rx;
    logic [1:0]  chk_count;
    logic [7:0]  field_no;
    logic        point_seen;
    logic [15:0] lat_whole_acc;
    logic [31:0] lat_frac_acc;
    logic [15:0] lon_whole_acc;
    logic [31:0] lon_frac_acc;
    logic [1:0]  lat_sign_acc;
    logic [1:0]  lon_sign_acc;
    logic [15:0] alt_acc;
    logic [1:0]  alt_sign_acc;
    logic [7:0]  sats_acc;
    logic        metric_flag;
    logic [1:0]  held_lat_sign;
    logic [15:0] held_lat_whole;
    logic [15:0] held_lat_frac;
    logic [1:0]  held_lon_sign;
    logic [15:0] held_lon_whole;
    logic [15:0] held_lon_frac;

    assign o_errors = fault_count;

    task automatic report_fault(input string msg);
        $display("telemetry checker: %s", msg);
        fault_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_fault($sformatf("fix %0d %s: got %h, expected %h",
                                   fix_index, name, got, want));
    endtask

    function automatic logic [31:0] digit_value(input logic [7:0] c);
        return {24'd0, c} - {24'd0, DEC_BASE};
    endfunction

    // Clear what a new frame starts from; the units flag and held position survive
    task automatic clear_frame();
        in_star       = 1'b0;
        sum_xor       = 8'd0;
        chk_rx        = 16'd0;
        chk_count     = 2'd0;
        field_no      = 8'd0;
        lat_whole_acc = 16'd0;
        lat_frac_acc  = 32'd0;
        lon_whole_acc = 16'd0;
        lon_frac_acc  = 32'd0;
        lat_sign_acc  = SIGN_NONE;
        lon_sign_acc  = SIGN_NONE;
        alt_acc       = 16'd0;
        alt_sign_acc  = SIGN_NONE;
        sats_acc      = 8'd0;
    endtask

    task automatic parse_byte(input logic [7:0] c);
        logic [15:0] hex_add;
        logic [31:0] quot;
        t_fix        fix;
        if (!in_frame) begin
            if (c == C_DOLLAR) begin
                clear_frame();
                in_frame = 1'b1;
            end
        end else if (c == C_R || c == C_V) begin
            sum_xor ^= c;
        end else if (c == C_STAR) begin
            in_star = 1'b1;
        end else if (chk_count == CHK_DIGITS_END) begin
            fix.ok = (chk_rx == {8'd0, sum_xor});
            if (fix.ok) begin
                held_lat_sign  = lat_sign_acc;
                held_lat_whole = lat_whole_acc;
                quot           = lat_frac_acc / FRAC_SCALE;
                held_lat_frac  = quot[15:0];
                held_lon_sign  = lon_sign_acc;
                held_lon_whole = lon_whole_acc;
                quot           = lon_frac_acc / FRAC_SCALE;
                held_lon_frac  = quot[15:0];
            end
            in_frame = 1'b0;
            case (alt_sign_acc)
                SIGN_POS: fix.altitude = alt_acc;
                SIGN_NEG: fix.altitude = 16'd0 - alt_acc;
                default:  fix.altitude = 16'd0;
            endcase
            fix.lat_sign   = held_lat_sign;
            fix.lat_whole  = held_lat_whole;
            fix.lat_frac   = held_lat_frac;
            fix.lon_sign   = held_lon_sign;
            fix.lon_whole  = held_lon_whole;
            fix.lon_frac   = held_lon_frac;
            fix.satellites = sats_acc;
            fix.metric     = metric_flag;
            fixes_due.push_back(fix);
        end else begin
            if (in_star) begin
                if (c >= C_ZERO && c <= C_NINE)
                    hex_add = {8'd0, c} - {8'd0, DEC_BASE};
                else
                    hex_add = {8'd0, c} - {8'd0, HEX_BASE};
                chk_count = chk_count + 2'd1;
                chk_rx    = chk_rx * HEX_RADIX + hex_add;
            end else begin
                sum_xor ^= c;
            end
            if (c == C_COMMA) begin
                field_no   = field_no + 8'd1;
                point_seen = 1'b0;
            end else begin
                // Checksum digits still land in whatever field is current
                case (field_no)
                    F_VALID: begin
                        if (c == C_ZERO) in_frame = 1'b0;
                    end
                    F_UNITS: begin
                        if (c == C_ZERO) metric_flag = 1'b0;
                        else if (c == C_ONE) metric_flag = 1'b1;
                    end
                    F_LAT: begin
                        if (c == C_POINT) point_seen = 1'b1;
                        else if (!point_seen)
                            lat_whole_acc = 16'(lat_whole_acc * DEC_RADIX + digit_value(c));
                        else
                            lat_frac_acc = lat_frac_acc * DEC_RADIX + digit_value(c);
                    end
                    F_LAT_HEMI: begin
                        if (c == C_N) lat_sign_acc = SIGN_POS;
                        else if (c == C_S) lat_sign_acc = SIGN_NEG;
                    end
                    F_LON: begin
                        if (c == C_POINT) point_seen = 1'b1;
                        else if (!point_seen)
                            lon_whole_acc = 16'(lon_whole_acc * DEC_RADIX + digit_value(c));
                        else
                            lon_frac_acc = lon_frac_acc * DEC_RADIX + digit_value(c);
                    end
                    F_LON_SIDE: begin
                        if (c == C_E) lon_sign_acc = SIGN_POS;
                        else if (c == C_W) lon_sign_acc = SIGN_NEG;
                    end
                    F_ALT: begin
                        if (c == C_POINT) point_seen = 1'b1;
                        else if (c == C_MINUS) alt_sign_acc = SIGN_NEG;
                        else if (c == C_PLUS) alt_sign_acc = SIGN_POS;
                        else if (!point_seen)
                            alt_acc = 16'(alt_acc * DEC_RADIX + digit_value(c));
                    end
                    F_SATS: begin
                        sats_acc = 8'(sats_acc * DEC_RADIX + digit_value(c));
                    end
                    default: ;
                endcase
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_fix want;
        if (!i_rst_n) begin
            clear_frame();
            in_frame       = 1'b0;
            point_seen     = 1'b0;
            metric_flag    = 1'b0;
            held_lat_sign  = SIGN_NONE;
            held_lat_whole = 16'd0;
            held_lat_frac  = 16'd0;
            held_lon_sign  = SIGN_NONE;
            held_lon_whole = 16'd0;
            held_lon_frac  = 16'd0;
            fixes_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (fixes_due.size() == 0) begin
                    report_fault($sformatf("fix %0d arrived with no frame closed", fix_index));
                end else begin
                    want = fixes_due.pop_front();
                    check_field("checksum_ok", {15'd0, i_m_tuser[0]}, {15'd0, want.ok});
                    check_field("metric_units", {15'd0, i_m_tuser[1]}, {15'd0, want.metric});
                    check_field("lat_sign", {14'd0, i_m_tdata[1:0]}, {14'd0, want.lat_sign});
                    check_field("lat_whole", i_m_tdata[17:2], want.lat_whole);
                    check_field("lat_frac", i_m_tdata[33:18], want.lat_frac);
                    check_field("lon_sign", {14'd0, i_m_tdata[35:34]}, {14'd0, want.lon_sign});
                    check_field("lon_whole", i_m_tdata[51:36], want.lon_whole);
                    check_field("lon_frac", i_m_tdata[67:52], want.lon_frac);
                    check_field("altitude", i_m_tdata[83:68], want.altitude);
                    check_field("satellites", {8'd0, i_m_tdata[91:84]},
                                {8'd0, want.satellites});
                end
                fix_index++;
            end
            if (i_s_tvalid && i_s_tready)
                parse_byte(i_s_tdata);
        end
        o_outstanding <= fixes_due.size();
    end

endmodule

>>> dv/telemetry_sentence_parser_test.sv
// Testbench top of the telemetry sentence parser: sentence stimulus, flow control and verdict.
module telemetry_sentence_parser_test;
    import tsp_pkg::*;

    localparam int          ITEM_TARGET    = 1750;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          TAIL_CYCLES    = 20;
    localparam logic [7:0]  C_HEX_A        = 8'h41;
    localparam logic [7:0]  C_LETTER_A     = 8'h41;
    localparam logic [7:0]  C_CR           = 8'h0D;

    logic                clk;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata  = 8'd0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [W_TDATA-1:0]  m_tdata;
    logic [W_TUSER-1:0]  m_tuser;

    int         errors;
    int         outstanding;
    int         items_sent  = 0;
    int         tx_idle_pct = 29;
    int         rx_idle_pct = 76;
    int         quiet_cycles = 0;
    logic [7:0] line_q[$];

    telemetry_sentence_parser DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    telemetry_sentence_parser_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .o_errors      (errors),
        .o_outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // End the run once nothing has moved on either channel for too long
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("telemetry_sentence_parser_test: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic put_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;
        if (items_sent < 600) begin
            tx_idle_pct = 29;
            rx_idle_pct = 76;
        end else if (items_sent < 1200) begin
            tx_idle_pct = 76;
            rx_idle_pct = 29;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    endtask

    task automatic send_line();
        foreach (line_q[i]) put_byte(line_q[i]);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? C_ZERO + {4'd0, n} : C_HEX_A + {4'd0, n} - 8'd10;
    endfunction

    // Append star, two checksum digits and a terminator, then send
    task automatic close_sentence(input bit good);
        logic [7:0] sum;
        logic [7:0] tx_sum;
        int         i;
        int         first;
        sum   = 8'd0;
        first = 0;
        // Sum the bytes after the opening dollar, skipping any stray lead-in
        while (first < line_q.size() && line_q[first] != C_DOLLAR) first++;
        for (i = first + 1; i < line_q.size() && line_q[i] != C_STAR; i++)
            sum ^= line_q[i];
        tx_sum = good ? sum : sum ^ 8'($urandom_range(1, 255));
        line_q.push_back(C_STAR);
        line_q.push_back(hex_char(tx_sum[7:4]));
        line_q.push_back(hex_char(tx_sum[3:0]));
        line_q.push_back(($urandom_range(0, 3) != 0) ? C_CR : 8'($urandom_range(0, 255)));
        send_line();
    endtask

    // Occasionally slip a stray byte in ahead of the wanted one
    task automatic push_char(input logic [7:0] c);
        if ($urandom_range(0, 99) < 2)
            line_q.push_back(8'($urandom_range(0, 255)));
        line_q.push_back(c);
    endtask

    task automatic add_digits(input int n);
        repeat (n) push_char(C_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic add_decimal(input int whole_digits, input int frac_digits);
        add_digits(whole_digits);
        if ($urandom_range(0, 3) != 0) begin
            push_char(C_POINT);
            add_digits(frac_digits);
        end
    endtask

    function automatic logic [7:0] pick_side(input logic [7:0] a, input logic [7:0] b);
        int r;
        r = $urandom_range(0, 19);
        if (r < 9) return a;
        if (r < 18) return b;
        return 8'($urandom_range(32, 126));
    endfunction

    initial begin
        int r;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Stray bytes outside a frame, then a frame aborted by its validity field
        line_q = {8'h00, 8'hFF, C_DOLLAR, C_ZERO};
        send_line();
        // Dollar and V inside a frame, a repeated star, south latitude
        line_q = {C_DOLLAR, C_V, C_DOLLAR, C_COMMA, C_ONE, C_COMMA, C_COMMA,
                  C_NINE, C_POINT, C_NINE, C_COMMA, C_S, C_STAR};
        close_sentence(1'b1);
        // Comma and a top-bit byte read as checksum digits
        line_q = {C_DOLLAR, C_COMMA, C_STAR, C_COMMA, 8'hFF, C_CR};
        send_line();

        while (items_sent < ITEM_TARGET) begin
            line_q = {};
            repeat ($urandom_range(0, 2)) line_q.push_back(8'($urandom_range(0, 255)));
            line_q.push_back(C_DOLLAR);
            r = $urandom_range(0, 19);
            if (r == 0) push_char(C_ZERO);
            else if (r != 1) push_char(C_LETTER_A);
            push_char(C_COMMA);
            if ($urandom_range(0, 9) < 8) push_char(C_ZERO + 8'($urandom_range(0, 1)));
            else push_char(8'($urandom_range(32, 126)));
            push_char(C_COMMA);
            add_digits($urandom_range(0, 6));
            push_char(C_COMMA);
            add_decimal($urandom_range(0, 5), $urandom_range(0, 10));
            push_char(C_COMMA);
            push_char(pick_side(C_N, C_S));
            push_char(C_COMMA);
            add_decimal($urandom_range(0, 5), $urandom_range(0, 10));
            push_char(C_COMMA);
            push_char(pick_side(C_E, C_W));
            push_char(C_COMMA);
            add_digits($urandom_range(0, 3));
            push_char(C_COMMA);
            r = $urandom_range(0, 2);
            if (r == 0) push_char(C_MINUS);
            else if (r == 1) push_char(C_PLUS);
            add_decimal($urandom_range(0, 6), $urandom_range(0, 2));
            // Sometimes run on through fields of at most one digit up to the satellite count
            if ($urandom_range(0, 2) == 0) begin
                repeat (15) begin
                    push_char(C_COMMA);
                    add_digits($urandom_range(0, 1));
                end
                add_digits($urandom_range(1, 3));
            end
            close_sentence($urandom_range(0, 99) < 85);
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0) begin
            $display("telemetry_sentence_parser_test: clean");
        end else begin
            $display("telemetry_sentence_parser_test: errors");
        end
        $finish;
    end

endmodule
